>>> sv/eitsp_pkg.sv
// shared types, constants and helpers of the event information table section parser
package eitsp_pkg;

   // section length bookkeeping
   localparam int HEADER_OVERHEAD = 5;
   localparam int CRC_BYTES = 4;
   localparam int TABLE_FIX_BYTES = 6;
   localparam int EVENT_FIX_BYTES = 12;
   localparam int DESC_FIX_BYTES = 2;
   localparam int FIXED_OVERHEAD = HEADER_OVERHEAD + CRC_BYTES + TABLE_FIX_BYTES;

   // result queue sizing
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // table id ranges
   localparam logic [7:0] TID_PF_ACTUAL = 8'h4e;
   localparam logic [7:0] TID_PF_OTHER = 8'h4f;
   localparam logic [3:0] TID_SCHED_ACTUAL_HI = 4'h5;
   localparam logic [3:0] TID_SCHED_OTHER_HI = 4'h6;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HEADER,
      PH_EVENT,
      PH_TAG,
      PH_LEN,
      PH_SKIP
   } phase_type;

   typedef enum logic [3:0] {
      KIND_HEADER       = 4'd0,
      KIND_EVENT        = 4'd1,
      KIND_DESC         = 4'd2,
      KIND_DONE_PF      = 4'd3,
      KIND_DONE_SCHED   = 4'd4,
      KIND_DONE_UNKNOWN = 4'd5,
      KIND_LEN_ERR      = 4'd6,
      KIND_DESC_ERR     = 4'd7,
      KIND_OVERRUN      = 4'd8,
      KIND_DROPPED      = 4'd9
   } kind_type;

   typedef enum logic [1:0] {
      CLASS_PF,
      CLASS_SCHED,
      CLASS_UNKNOWN
   } class_type;

   typedef struct packed {
      kind_type    kind;
      logic [47:0] tbl_ids;
      logic [95:0] event_hdr;
      logic [7:0]  desc_tag;
      logic [7:0]  desc_length;
      logic        last_of_run;
   } result_type;

   // up to two results made by one byte
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   // section-done kind for a table class
   function automatic kind_type done_kind(input class_type cls);
      kind_type k;
      case (cls)
         CLASS_PF:    k = KIND_DONE_PF;
         CLASS_SCHED: k = KIND_DONE_SCHED;
         default:     k = KIND_DONE_UNKNOWN;
      endcase
      return k;
   endfunction

   function automatic result_type make_result(input kind_type k, input logic [47:0] hdr,
                                              input logic [95:0] ev, input logic [7:0] tag,
                                              input logic [7:0] len, input logic last);
      result_type r;
      r.kind = k;
      r.tbl_ids = hdr;
      r.event_hdr = ev;
      r.desc_tag = tag;
      r.desc_length = len;
      r.last_of_run = last;
      return r;
   endfunction

endpackage

>>> sv/eitsp_parser.sv
// section byte parser: phase state, counters, header shifters and result build
module eitsp_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic [7:0]         data_byte,
   input  logic               section_start,
   input  logic [11:0]        sec_len,
   input  logic [7:0]         tbl_code,
   input  logic               parse_schedule,
   output eitsp_pkg::push_type push
);

   eitsp_pkg::phase_type phase_ff, phase_in;
   logic [3:0]           idx_ff, idx_in;
   logic [12:0]          event_left_ff, event_left_in;
   logic [12:0]          loop_left_ff, loop_left_in;
   logic [7:0]           desc_left_ff, desc_left_in;
   logic [47:0]          hdr_ff, hdr_in;
   logic [95:0]          ev_ff, ev_in;
   eitsp_pkg::class_type class_ff, class_in;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= eitsp_pkg::PH_IDLE;
         idx_ff <= '0;
         event_left_ff <= '0;
         loop_left_ff <= '0;
         desc_left_ff <= '0;
         hdr_ff <= '0;
         ev_ff <= '0;
         class_ff <= eitsp_pkg::CLASS_PF;
      end else if (go) begin
         phase_ff <= phase_in;
         idx_ff <= idx_in;
         event_left_ff <= event_left_in;
         loop_left_ff <= loop_left_in;
         desc_left_ff <= desc_left_in;
         hdr_ff <= hdr_in;
         ev_ff <= ev_in;
         class_ff <= class_in;
      end
   end

   logic                 sched;
   logic                 len_bad;
   logic [12:0]          need_ev;
   logic [8:0]           need_desc;
   logic [12:0]          left_after;
   logic [7:0]           desc_dec;
   logic [1:0]           n;
   eitsp_pkg::kind_type  k0, k1;
   logic [7:0]           tag0, len0;

   // next state and results of one byte
   always_comb begin
      phase_in = phase_ff;
      idx_in = idx_ff;
      event_left_in = event_left_ff;
      loop_left_in = loop_left_ff;
      desc_left_in = desc_left_ff;
      hdr_in = hdr_ff;
      ev_in = ev_ff;
      class_in = class_ff;
      n = 2'd0;
      k0 = eitsp_pkg::KIND_HEADER;
      k1 = eitsp_pkg::KIND_HEADER;
      tag0 = '0;
      len0 = '0;

      sched = (tbl_code[7:4] == eitsp_pkg::TID_SCHED_ACTUAL_HI) ||
              (tbl_code[7:4] == eitsp_pkg::TID_SCHED_OTHER_HI);
      len_bad = (sec_len < 12'(eitsp_pkg::FIXED_OVERHEAD)) ||
                ((sec_len > 12'(eitsp_pkg::FIXED_OVERHEAD)) &&
                 (sec_len < 12'(eitsp_pkg::FIXED_OVERHEAD + eitsp_pkg::EVENT_FIX_BYTES)));
      // bytes the event needs (fixed part plus loop length) once this byte completes its header
      need_ev = 13'(eitsp_pkg::EVENT_FIX_BYTES) + {1'b0, ev_ff[3:0], data_byte};
      need_desc = 9'(eitsp_pkg::DESC_FIX_BYTES) + {1'b0, data_byte};
      left_after = event_left_ff;
      desc_dec = (desc_left_ff != 8'd0) ? desc_left_ff - 8'd1 : 8'd0;

      if (section_start) begin
         // new section restarts everything
         hdr_in = '0;
         ev_in = '0;
         loop_left_in = '0;
         desc_left_in = '0;
         event_left_in = '0;
         idx_in = 4'd1;
         phase_in = eitsp_pkg::PH_IDLE;
         if (tbl_code == eitsp_pkg::TID_PF_ACTUAL || tbl_code == eitsp_pkg::TID_PF_OTHER) begin
            class_in = eitsp_pkg::CLASS_PF;
         end else if (sched) begin
            class_in = eitsp_pkg::CLASS_SCHED;
         end else begin
            class_in = eitsp_pkg::CLASS_UNKNOWN;
         end
         if (sched && !parse_schedule) begin
            n = 2'd1;
            k0 = eitsp_pkg::KIND_DROPPED;
         end else if (len_bad) begin
            n = 2'd1;
            k0 = eitsp_pkg::KIND_LEN_ERR;
         end else begin
            event_left_in = 13'(sec_len - 12'(eitsp_pkg::FIXED_OVERHEAD));
            hdr_in = {40'd0, data_byte};
            phase_in = eitsp_pkg::PH_HEADER;
         end
      end else begin
         case (phase_ff)
            eitsp_pkg::PH_HEADER: begin
               hdr_in = {hdr_ff[39:0], data_byte};
               idx_in = idx_ff + 4'd1;
               if (idx_in >= 4'(eitsp_pkg::TABLE_FIX_BYTES)) begin
                  k0 = eitsp_pkg::KIND_HEADER;
                  if (event_left_ff == 13'd0) begin
                     n = 2'd2;
                     k1 = eitsp_pkg::done_kind(class_ff);
                     phase_in = eitsp_pkg::PH_IDLE;
                  end else begin
                     n = 2'd1;
                     phase_in = eitsp_pkg::PH_EVENT;
                     idx_in = 4'd0;
                  end
               end
            end
            eitsp_pkg::PH_EVENT: begin
               ev_in = {ev_ff[87:0], data_byte};
               idx_in = idx_ff + 4'd1;
               if (idx_in >= 4'(eitsp_pkg::EVENT_FIX_BYTES)) begin
                  k0 = eitsp_pkg::KIND_EVENT;
                  left_after = event_left_ff - need_ev;
                  if (need_ev > event_left_ff) begin
                     n = 2'd2;
                     k1 = eitsp_pkg::KIND_OVERRUN;
                     phase_in = eitsp_pkg::PH_IDLE;
                  end else begin
                     event_left_in = left_after;
                     loop_left_in = {1'b0, ev_in[11:0]};
                     if (ev_in[11:0] != 12'd0) begin
                        n = 2'd1;
                        phase_in = eitsp_pkg::PH_TAG;
                     end else if (left_after == 13'd0) begin
                        n = 2'd2;
                        k1 = eitsp_pkg::done_kind(class_ff);
                        phase_in = eitsp_pkg::PH_IDLE;
                     end else begin
                        n = 2'd1;
                        phase_in = eitsp_pkg::PH_EVENT;
                        idx_in = 4'd0;
                     end
                  end
               end
            end
            eitsp_pkg::PH_TAG: begin
               desc_left_in = data_byte;
               phase_in = eitsp_pkg::PH_LEN;
            end
            eitsp_pkg::PH_LEN: begin
               tag0 = desc_left_ff;
               len0 = data_byte;
               if ({4'd0, need_desc} > loop_left_ff) begin
                  n = 2'd1;
                  k0 = eitsp_pkg::KIND_DESC_ERR;
                  phase_in = eitsp_pkg::PH_IDLE;
               end else begin
                  loop_left_in = loop_left_ff - {4'd0, need_desc};
                  k0 = eitsp_pkg::KIND_DESC;
                  desc_left_in = data_byte;
                  n = 2'd1;
                  if (data_byte != 8'd0) begin
                     phase_in = eitsp_pkg::PH_SKIP;
                  end else if (loop_left_in != 13'd0) begin
                     phase_in = eitsp_pkg::PH_TAG;
                  end else if (event_left_ff == 13'd0) begin
                     n = 2'd2;
                     k1 = eitsp_pkg::done_kind(class_ff);
                     phase_in = eitsp_pkg::PH_IDLE;
                  end else begin
                     phase_in = eitsp_pkg::PH_EVENT;
                     idx_in = 4'd0;
                  end
               end
            end
            eitsp_pkg::PH_SKIP: begin
               // payload byte of a descriptor, not reported
               desc_left_in = desc_dec;
               if (desc_dec == 8'd0) begin
                  if (loop_left_ff != 13'd0) begin
                     phase_in = eitsp_pkg::PH_TAG;
                  end else if (event_left_ff == 13'd0) begin
                     n = 2'd1;
                     k0 = eitsp_pkg::done_kind(class_ff);
                     phase_in = eitsp_pkg::PH_IDLE;
                  end else begin
                     phase_in = eitsp_pkg::PH_EVENT;
                     idx_in = 4'd0;
                  end
               end
            end
            default: begin
               phase_in = eitsp_pkg::PH_IDLE;
            end
         endcase
      end
   end

   // result beats for the queue
   always_comb begin
      push.count = go ? n : 2'd0;
      push.first = eitsp_pkg::make_result(k0, hdr_in, ev_in, tag0, len0, n == 2'd1);
      push.second = eitsp_pkg::make_result(k1, hdr_in, ev_in, 8'd0, 8'd0, 1'b1);
   end

endmodule

>>> sv/eitsp_out_queue.sv
// small result queue: takes up to two beats a cycle, hands out one
module eitsp_out_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  eitsp_pkg::push_type   push,
   input  logic                  pop,
   output logic                  room,
   output logic                  head_valid,
   output eitsp_pkg::result_type head
);

   eitsp_pkg::result_type           q_ff [eitsp_pkg::QUEUE_DEPTH];
   logic [eitsp_pkg::QPTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [eitsp_pkg::QCNT_W-1:0]    count_ff, count_in;
   logic [eitsp_pkg::QPTR_W-1:0]    wr_next;

   assign wr_next = wr_ptr_ff + eitsp_pkg::QPTR_W'(1);
   assign count_in = count_ff + eitsp_pkg::QCNT_W'(push.count) -
                     eitsp_pkg::QCNT_W'(pop);

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + eitsp_pkg::QPTR_W'(push.count);
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + eitsp_pkg::QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         q_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         q_ff[wr_next] <= push.second;
      end
   end

   assign room = count_ff <= eitsp_pkg::QCNT_W'(eitsp_pkg::QUEUE_DEPTH - 2);
   assign head_valid = count_ff != '0;
   assign head = q_ff[rd_ptr_ff];

endmodule

>>> sv/eit_section_event_parser.sv
// top level of the event information table section parser
//
//   channel | direction | beat contents
//   req_    | in        | one section data byte with start flag, length and table id
//   rsp_    | out       | one header, event, descriptor, done, dropped or error record
//   csr_    | in        | parse_schedule enable, written with csr_wr_en
//
// A byte is taken every cycle while req_stall is low; its first result is registered in the
// input register and then in the result queue before it shows on rsp_. A byte that makes two
// results gives two beats; the input register holds it until the four-entry result queue has
// room for two beats. Output stall backs up through the queue into req_stall.
// Synchronous reset returns the parser to idle and empties the queue.
module eit_section_event_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_section_start,
   input  logic [11:0] req_sec_len,
   input  logic [7:0]  req_tbl_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_kind,
   output logic [47:0] rsp_tbl_ids,
   output logic [15:0] rsp_evt_num,
   output logic [39:0] rsp_start_stamp,
   output logic [23:0] rsp_duration,
   output logic [2:0]  rsp_run_state,
   output logic        rsp_scramble_flag,
   output logic [11:0] rsp_loop_length,
   output logic [7:0]  rsp_desc_tag,
   output logic [7:0]  rsp_desc_length,
   output logic        rsp_last_of_run,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   logic                  parse_schedule_ff;
   logic                  in_valid_ff;
   logic [7:0]            data_byte_ff;
   logic                  section_start_ff;
   logic [11:0]           sec_len_ff;
   logic [7:0]            tbl_code_ff;
   logic                  room;
   logic                  go;
   logic                  pop;
   eitsp_pkg::push_type   push;
   eitsp_pkg::result_type head;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         parse_schedule_ff <= 1'b0;
      end else if (csr_wr_en) begin
         parse_schedule_ff <= csr_wr_data;
      end
   end

   assign go = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;

   // input beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         data_byte_ff <= req_data_byte;
         section_start_ff <= req_section_start;
         sec_len_ff <= req_sec_len;
         tbl_code_ff <= req_tbl_code;
      end
   end

   eitsp_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .go             (go),
      .data_byte      (data_byte_ff),
      .section_start  (section_start_ff),
      .sec_len        (sec_len_ff),
      .tbl_code       (tbl_code_ff),
      .parse_schedule (parse_schedule_ff),
      .push           (push)
   );

   assign pop = rsp_valid && !rsp_stall;

   eitsp_out_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .room       (room),
      .head_valid (rsp_valid),
      .head       (head)
   );

   // result fields
   assign rsp_kind = head.kind;
   assign rsp_tbl_ids = head.tbl_ids;
   assign rsp_evt_num = head.event_hdr[95:80];
   assign rsp_start_stamp = head.event_hdr[79:40];
   assign rsp_duration = head.event_hdr[39:16];
   assign rsp_run_state = head.event_hdr[15:13];
   assign rsp_scramble_flag = head.event_hdr[12];
   assign rsp_loop_length = head.event_hdr[11:0];
   assign rsp_desc_tag = head.desc_tag;
   assign rsp_desc_length = head.desc_length;
   assign rsp_last_of_run = head.last_of_run;

endmodule

>>> tb/sv/eit_section_event_parser_tb.sv
// self-checking testbench of the event information table section parser
module eit_section_event_parser_tb;

   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 12;
   localparam int MAX_REPORTS = 10;

   // directed section: pf table, one event whose loop runs past the section
   localparam logic [7:0] OVERRUN_SECTION [18] = '{
      8'hff, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78,
      8'hab, 8'hcd, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'hf0, 8'h01
   };

   typedef struct {
      logic [7:0]  data_byte;
      logic        section_start;
      logic [11:0] sec_len;
      logic [7:0]  tbl_code;
   } sec_byte_type;

   typedef struct {
      eitsp_pkg::kind_type kind;
      logic [47:0] tbl_ids;
      logic [15:0] evt_num;
      logic [39:0] start_stamp;
      logic [23:0] duration;
      logic [2:0]  run_state;
      logic        scramble_flag;
      logic [11:0] loop_length;
      logic [7:0]  desc_tag;
      logic [7:0]  desc_length;
      logic        last_of_run;
   } parse_rec_type;

   // block ports
   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        req_section_start = 1'b0;
   logic [11:0] req_sec_len = '0;
   logic [7:0]  req_tbl_code = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_kind;
   logic [47:0] rsp_tbl_ids;
   logic [15:0] rsp_evt_num;
   logic [39:0] rsp_start_stamp;
   logic [23:0] rsp_duration;
   logic [2:0]  rsp_run_state;
   logic        rsp_scramble_flag;
   logic [11:0] rsp_loop_length;
   logic [7:0]  rsp_desc_tag;
   logic [7:0]  rsp_desc_length;
   logic        rsp_last_of_run;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;

   // parser copy kept by the scoreboard
   logic                 sched_enable = 1'b0;
   eitsp_pkg::phase_type cur_phase = eitsp_pkg::PH_IDLE;
   logic [3:0]           byte_pos = '0;
   logic [12:0]          evt_remaining = '0;
   logic [12:0]          loop_remaining = '0;
   logic [7:0]           desc_remaining = '0;
   logic [47:0]          hdr_acc = '0;
   logic [95:0]          evt_acc = '0;
   eitsp_pkg::class_type tbl_class = eitsp_pkg::CLASS_PF;
   parse_rec_type        step_recs [2];
   int                   step_cnt;

   // stimulus and scoreboard bookkeeping
   sec_byte_type  section_bytes_q [$];
   parse_rec_type parsed_records_q [$];
   int            queued_items = 0;
   int            send_pct = 0;
   int            stall_pct = 0;
   int            send_gap = 0;
   int            stall_left = 0;
   logic          byte_taken = 1'b0;
   int            quiet_cycles = 0;
   int            bytes_in = 0;
   int            results_seen = 0;
   int            mismatches = 0;
   int            csr_writes = 0;
   int            kind_seen [16];

   eit_section_event_parser DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_section_start  (req_section_start),
      .req_sec_len        (req_sec_len),
      .req_tbl_code       (req_tbl_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_tbl_ids        (rsp_tbl_ids),
      .rsp_evt_num        (rsp_evt_num),
      .rsp_start_stamp    (rsp_start_stamp),
      .rsp_duration       (rsp_duration),
      .rsp_run_state      (rsp_run_state),
      .rsp_scramble_flag  (rsp_scramble_flag),
      .rsp_loop_length    (rsp_loop_length),
      .rsp_desc_tag       (rsp_desc_tag),
      .rsp_desc_length    (rsp_desc_length),
      .rsp_last_of_run    (rsp_last_of_run),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // clock, period 8
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // record one expected result from the current header and event fields
   task automatic add_record(input eitsp_pkg::kind_type k, input logic [7:0] tag,
                             input logic [7:0] dlen);
      parse_rec_type r;
      r.kind = k;
      r.tbl_ids = hdr_acc;
      r.evt_num = evt_acc[95:80];
      r.start_stamp = evt_acc[79:40];
      r.duration = evt_acc[39:16];
      r.run_state = evt_acc[15:13];
      r.scramble_flag = evt_acc[12];
      r.loop_length = evt_acc[11:0];
      r.desc_tag = tag;
      r.desc_length = dlen;
      r.last_of_run = 1'b0;
      step_recs[step_cnt] = r;
      step_cnt++;
   endtask

   // an event (or the header) is complete: next event or section done
   task automatic close_event();
      if (evt_remaining == 0) begin
         case (tbl_class)
            eitsp_pkg::CLASS_PF:    add_record(eitsp_pkg::KIND_DONE_PF, '0, '0);
            eitsp_pkg::CLASS_SCHED: add_record(eitsp_pkg::KIND_DONE_SCHED, '0, '0);
            default:                add_record(eitsp_pkg::KIND_DONE_UNKNOWN, '0, '0);
         endcase
         cur_phase = eitsp_pkg::PH_IDLE;
      end else begin
         cur_phase = eitsp_pkg::PH_EVENT;
         byte_pos = '0;
      end
   endtask

   // a descriptor is complete: next descriptor or end of event
   task automatic close_desc();
      if (loop_remaining > 0)
         cur_phase = eitsp_pkg::PH_TAG;
      else
         close_event();
   endtask

   // advance the parser copy by one accepted byte and queue its results
   task automatic parse_section_byte(input sec_byte_type it);
      int          evlen;
      int          need;
      logic [11:0] loop;
      logic [7:0]  tag;
      logic        is_sched;
      int          i;
      step_cnt = 0;
      if (it.section_start) begin
         evlen = int'(it.sec_len) - eitsp_pkg::FIXED_OVERHEAD;
         is_sched = (it.tbl_code[7:4] == eitsp_pkg::TID_SCHED_ACTUAL_HI) ||
                    (it.tbl_code[7:4] == eitsp_pkg::TID_SCHED_OTHER_HI);
         hdr_acc = '0;
         evt_acc = '0;
         loop_remaining = '0;
         desc_remaining = '0;
         if (it.tbl_code == eitsp_pkg::TID_PF_ACTUAL || it.tbl_code == eitsp_pkg::TID_PF_OTHER)
            tbl_class = eitsp_pkg::CLASS_PF;
         else if (is_sched)
            tbl_class = eitsp_pkg::CLASS_SCHED;
         else
            tbl_class = eitsp_pkg::CLASS_UNKNOWN;
         cur_phase = eitsp_pkg::PH_IDLE;
         if (is_sched && !sched_enable) begin
            add_record(eitsp_pkg::KIND_DROPPED, '0, '0);
         end else if (evlen < 0 || (evlen > 0 && evlen < eitsp_pkg::EVENT_FIX_BYTES)) begin
            add_record(eitsp_pkg::KIND_LEN_ERR, '0, '0);
         end else begin
            evt_remaining = evlen[12:0];
            hdr_acc = {40'b0, it.data_byte};
            byte_pos = 4'd1;
            cur_phase = eitsp_pkg::PH_HEADER;
         end
      end else begin
         case (cur_phase)
            eitsp_pkg::PH_HEADER: begin
               hdr_acc = {hdr_acc[39:0], it.data_byte};
               byte_pos = byte_pos + 4'd1;
               if (byte_pos >= eitsp_pkg::TABLE_FIX_BYTES) begin
                  add_record(eitsp_pkg::KIND_HEADER, '0, '0);
                  close_event();
               end
            end
            eitsp_pkg::PH_EVENT: begin
               evt_acc = {evt_acc[87:0], it.data_byte};
               byte_pos = byte_pos + 4'd1;
               if (byte_pos >= eitsp_pkg::EVENT_FIX_BYTES) begin
                  loop = evt_acc[11:0];
                  need = eitsp_pkg::EVENT_FIX_BYTES + int'(loop);
                  add_record(eitsp_pkg::KIND_EVENT, '0, '0);
                  if (need > int'(evt_remaining)) begin
                     add_record(eitsp_pkg::KIND_OVERRUN, '0, '0);
                     cur_phase = eitsp_pkg::PH_IDLE;
                  end else begin
                     evt_remaining = evt_remaining - need[12:0];
                     loop_remaining = {1'b0, loop};
                     close_desc();
                  end
               end
            end
            eitsp_pkg::PH_TAG: begin
               desc_remaining = it.data_byte;
               cur_phase = eitsp_pkg::PH_LEN;
            end
            eitsp_pkg::PH_LEN: begin
               tag = desc_remaining;
               need = eitsp_pkg::DESC_FIX_BYTES + int'(it.data_byte);
               if (need > int'(loop_remaining)) begin
                  add_record(eitsp_pkg::KIND_DESC_ERR, tag, it.data_byte);
                  cur_phase = eitsp_pkg::PH_IDLE;
               end else begin
                  loop_remaining = loop_remaining - need[12:0];
                  add_record(eitsp_pkg::KIND_DESC, tag, it.data_byte);
                  desc_remaining = it.data_byte;
                  if (it.data_byte != 0)
                     cur_phase = eitsp_pkg::PH_SKIP;
                  else
                     close_desc();
               end
            end
            eitsp_pkg::PH_SKIP: begin
               if (desc_remaining != 0)
                  desc_remaining = desc_remaining - 8'd1;
               if (desc_remaining == 0)
                  close_desc();
            end
            default: cur_phase = eitsp_pkg::PH_IDLE;
         endcase
      end
      if (step_cnt > 0)
         step_recs[step_cnt - 1].last_of_run = 1'b1;
      for (i = 0; i < step_cnt; i++)
         parsed_records_q.insert(parsed_records_q.size(), step_recs[i]);
   endtask

   // queue one byte; length and table id are random when not a section start
   task automatic queue_byte(input logic [7:0] b, input logic s, input logic [11:0] l,
                             input logic [7:0] t, input bit counted);
      sec_byte_type it;
      it.data_byte = b;
      it.section_start = s;
      it.sec_len = s ? l : 12'($urandom);
      it.tbl_code = s ? t : 8'($urandom);
      section_bytes_q.insert(section_bytes_q.size(), it);
      if (counted)
         queued_items++;
   endtask

   function automatic logic [7:0] pick_tid();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4)
         return eitsp_pkg::TID_PF_ACTUAL | 8'($urandom_range(0, 1));
      else if (r < 7)
         return 8'($urandom_range(8'h50, 8'h6f));
      else
         return 8'($urandom);
   endfunction

   // well-formed section with random content; mode 1 corrupts it, mode 2 cuts it short
   task automatic queue_section(input logic [7:0] tid, input int mode);
      logic [7:0] body [$];
      logic [7:0] descs [$];
      int         dl_idx [$];
      int         marks [$];
      int         n_ev, n_desc, dlen, loop, slen, cut, pick;
      int         e, d, i;
      repeat (6) body.insert(body.size(), 8'($urandom));
      n_ev = $urandom_range(0, 3);
      for (e = 0; e < n_ev; e++) begin
         descs.delete();
         dl_idx.delete();
         n_desc = $urandom_range(0, 3);
         for (d = 0; d < n_desc; d++) begin
            dlen = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 255) : $urandom_range(0, 8);
            descs.insert(descs.size(), 8'($urandom));
            dl_idx.insert(dl_idx.size(), descs.size());
            descs.insert(descs.size(), 8'(dlen));
            repeat (dlen) descs.insert(descs.size(), 8'($urandom));
         end
         loop = descs.size();
         repeat (10) body.insert(body.size(), 8'($urandom));
         body.insert(body.size(), {3'($urandom), 1'($urandom), 4'(loop >> 8)});
         marks.insert(marks.size(), body.size());
         body.insert(body.size(), 8'(loop));
         foreach (dl_idx[k])
            marks.insert(marks.size(), body.size() + dl_idx[k]);
         foreach (descs[k])
            body.insert(body.size(), descs[k]);
      end
      slen = body.size() + eitsp_pkg::FIXED_OVERHEAD - eitsp_pkg::TABLE_FIX_BYTES;
      // bump a loop or descriptor length, or skew the section length
      if (mode == 1) begin
         if (marks.size() > 0 && $urandom_range(0, 2) != 0) begin
            pick = marks[$urandom_range(0, marks.size() - 1)];
            body[pick] = body[pick] + 8'($urandom_range(1, 30));
         end else begin
            slen = slen + int'($urandom_range(0, 6)) - 3;
         end
      end
      cut = (mode == 2) ? $urandom_range(1, body.size()) : body.size();
      for (i = 0; i < cut; i++)
         queue_byte(body[i], i == 0, 12'(slen), tid, 1'b1);
   endtask

   // random mix: mostly proper sections, plus broken ones and noise
   task automatic queue_random(input int count);
      int target, r;
      target = queued_items + count;
      while (queued_items < target) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            queue_section(pick_tid(), 0);
         end else if (r < 70) begin
            queue_section(pick_tid(), 1);
         end else if (r < 77) begin
            queue_section(pick_tid(), 2);
         end else if (r < 85) begin
            queue_byte(8'($urandom), 1'b1, 12'($urandom), 8'($urandom), 1'b1);
            repeat ($urandom_range(0, 16)) queue_byte(8'($urandom), 1'b0, '0, '0, 1'b1);
         end else if (r < 93) begin
            queue_byte(8'($urandom), 1'b1, 12'($urandom_range(0, 27)), pick_tid(), 1'b1);
         end else begin
            repeat ($urandom_range(1, 4)) queue_byte(8'($urandom), 1'b0, '0, '0, 1'b0);
         end
      end
   endtask

   // hold the sender until every expected result is in and the block has settled
   task automatic wait_drained();
      while (section_bytes_q.size() != 0 || req_valid)
         @(posedge clock);
      while (parsed_records_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sched_enable = v;
      csr_writes++;
   endtask

   // input driver: a beat stays up until taken, idle bursts between beats
   always @(negedge clock) begin
      sec_byte_type nxt;
      logic         drive_valid;
      drive_valid = req_valid && !byte_taken;
      if (!reset && !drive_valid) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (section_bytes_q.size() > 0) begin
            if (send_pct > 0 && $urandom_range(0, 99) < send_pct) begin
               send_gap = $urandom_range(0, 8);
            end else begin
               nxt = section_bytes_q.pop_front();
               drive_valid = 1'b1;
               req_data_byte <= nxt.data_byte;
               req_section_start <= nxt.section_start;
               req_sec_len <= nxt.sec_len;
               req_tbl_code <= nxt.tbl_code;
            end
         end
      end
      req_valid <= drive_valid;
   end

   // result stall in bursts
   always @(negedge clock) begin
      logic hold;
      hold = 1'b0;
      if (stall_left > 0) begin
         hold = 1'b1;
         stall_left--;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
         hold = 1'b1;
         stall_left = $urandom_range(0, 8);
      end
      rsp_stall <= hold;
   end

   // accepted bytes feed the parser copy, result beats are checked in order
   always @(posedge clock) begin
      sec_byte_type  got_in;
      parse_rec_type want;
      logic          hit;
      hit = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            got_in.data_byte = req_data_byte;
            got_in.section_start = req_section_start;
            got_in.sec_len = req_sec_len;
            got_in.tbl_code = req_tbl_code;
            parse_section_byte(got_in);
            bytes_in++;
            hit = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            hit = 1'b1;
            results_seen++;
            kind_seen[rsp_kind]++;
            if (parsed_records_q.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected result beat %0d: kind %0d", results_seen, rsp_kind);
            end else begin
               want = parsed_records_q.pop_front();
               if (want.kind !== rsp_kind || want.tbl_ids !== rsp_tbl_ids ||
                   want.evt_num !== rsp_evt_num || want.start_stamp !== rsp_start_stamp ||
                   want.duration !== rsp_duration ||
                   want.run_state !== rsp_run_state ||
                   want.scramble_flag !== rsp_scramble_flag ||
                   want.loop_length !== rsp_loop_length || want.desc_tag !== rsp_desc_tag ||
                   want.desc_length !== rsp_desc_length ||
                   want.last_of_run !== rsp_last_of_run) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $write("result beat %0d expected: kind %0d ids %h ev %h st %h dur %h",
                            results_seen, want.kind, want.tbl_ids, want.evt_num,
                            want.start_stamp, want.duration);
                     $display(" rs %0d ca %0d loop %h tag %h len %h last %0d",
                              want.run_state, want.scramble_flag, want.loop_length,
                              want.desc_tag, want.desc_length, want.last_of_run);
                     $write("result beat %0d actual:   kind %0d ids %h ev %h st %h dur %h",
                            results_seen, rsp_kind, rsp_tbl_ids, rsp_evt_num,
                            rsp_start_stamp, rsp_duration);
                     $display(" rs %0d ca %0d loop %h tag %h len %h last %0d",
                              rsp_run_state, rsp_scramble_flag, rsp_loop_length,
                              rsp_desc_tag, rsp_desc_length, rsp_last_of_run);
                  end
               end
            end
         end
      end
      quiet_cycles <= hit ? 0 : quiet_cycles + 1;
      byte_taken <= !reset && req_valid && !req_stall;
   end

   // watchdog on cycles with no beat on either channel
   initial begin
      while (quiet_cycles < QUIET_LIMIT)
         @(posedge clock);
      $display("no beat for %0d cycles, giving up", QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // reset, directed cases, then random phases across register settings
   initial begin
      foreach (kind_seen[k])
         kind_seen[k] = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // idle byte, dropped schedule, bad lengths, restart mid-section, overrun
      queue_byte(8'hff, 1'b0, '0, '0, 1'b1);
      queue_byte(8'h00, 1'b1, 12'hfff, 8'h50, 1'b1);
      queue_byte(8'hff, 1'b1, 12'h000, 8'h00, 1'b1);
      queue_byte(8'h5a, 1'b1, 12'hfff, 8'hff, 1'b1);
      queue_byte(8'h00, 1'b1, 12'd20, eitsp_pkg::TID_PF_ACTUAL, 1'b1);
      foreach (OVERRUN_SECTION[i])
         queue_byte(OVERRUN_SECTION[i], i == 0, 12'd27, eitsp_pkg::TID_PF_OTHER, 1'b1);

      send_pct = 15;
      stall_pct = 15;
      queue_random(300);
      wait_drained();

      write_csr(1'b1);
      send_pct = 50;
      stall_pct = 50;
      queue_random(400);
      wait_drained();

      write_csr(1'b0);
      send_pct = 30;
      stall_pct = 0;
      queue_random(250);
      wait_drained();

      // closing stretch at full rate
      write_csr(1'b1);
      send_pct = 0;
      stall_pct = 0;
      queue_random(300);
      wait_drained();

      $write("covered %0d bytes and %0d result beats: %0d headers, %0d events,",
             bytes_in, results_seen, kind_seen[eitsp_pkg::KIND_HEADER],
             kind_seen[eitsp_pkg::KIND_EVENT]);
      $display(" %0d descriptors, %0d sections done",
               kind_seen[eitsp_pkg::KIND_DESC],
               kind_seen[eitsp_pkg::KIND_DONE_PF] + kind_seen[eitsp_pkg::KIND_DONE_SCHED] +
               kind_seen[eitsp_pkg::KIND_DONE_UNKNOWN]);
      $write("errors seen: %0d length, %0d descriptor, %0d overrun,",
             kind_seen[eitsp_pkg::KIND_LEN_ERR], kind_seen[eitsp_pkg::KIND_DESC_ERR],
             kind_seen[eitsp_pkg::KIND_OVERRUN]);
      $display(" %0d dropped; %0d register writes",
               kind_seen[eitsp_pkg::KIND_DROPPED], csr_writes);
      if (mismatches == 0 && parsed_records_q.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
